[hdl/sie_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the safety interlock and escalation sequencer
// no dependencies; used by sie_step and safety_interlock_escalation_fsm

package sie_pkg;

    // counter width default
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // configuration register file
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GLITCH_LIMIT      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CALM_SWEEP_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE_TICKS      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCALATE_T1_TICKS = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCALATE_T2_TICKS = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESTOP_DANGER_HIGH = 3'd5;

    // operation codes
    localparam logic [1:0] OP_TICK         = 2'd0;
    localparam logic [1:0] OP_FORCE_ESTOP  = 2'd1;
    localparam logic [1:0] OP_CLEAR_GLITCH = 2'd2;

    // safety sequence codes
    localparam logic [1:0] MODE_PANIC = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;
    localparam logic [1:0] MODE_OK    = 2'd3;

    // watchdog escalation codes
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_MON  = 2'd1;
    localparam logic [1:0] ESC_HW   = 2'd2;
    localparam logic [1:0] ESC_CONT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       link_connected;
        logic       estop_level;
        logic       ack_level;
        logic       zero_speed_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  safety_mode;
        logic [1:0]  escalation_level;
        logic        contactor_relay_on;
        logic        hw_estop_relay_on;
        logic [15:0] calm_progress;
        logic [15:0] settle_progress;
        logic [15:0] glitch_total;
        logic        panic_estop_input;
        logic        panic_software_estop;
        logic        panic_link_lost;
    } out_item_t;

    typedef struct packed {
        logic [15:0] glitch_limit;
        logic [15:0] calm_sweep_ticks;
        logic [15:0] settle_ticks;
        logic [15:0] escalate_t1_ticks;
        logic [15:0] escalate_t2_ticks;
        logic        estop_danger_high;
    } cfg_t;

    typedef struct packed {
        logic estop;
        logic sw;
        logic link;
    } panic_flags_t;

    // fixed-width part of the sequencer state
    typedef struct packed {
        logic [1:0]   mode;
        logic [1:0]   prev_mode;
        logic [1:0]   escalation;
        logic [15:0]  calm_count;
        logic [15:0]  settle_count;
        logic         prev_link;
        logic         link_fault_latch;
        panic_flags_t flags;
    } seq_state_t;

endpackage

[hdl/sie_step.sv]
`timescale 1ns / 1ps
// next-state and result logic for one item of the interlock sequencer
// depends on sie_pkg

module sie_step #(
    parameter int COUNT_WIDTH = sie_pkg::COUNT_WIDTH_DEFAULT
) (
    input  sie_pkg::in_item_t   item,
    input  sie_pkg::cfg_t       cfg,
    input  sie_pkg::seq_state_t cur,
    input  logic [COUNT_WIDTH-1:0] danger_run,
    input  logic [COUNT_WIDTH-1:0] glitch_count,
    input  logic [COUNT_WIDTH-1:0] escalation_count,
    output sie_pkg::seq_state_t nxt,
    output logic [COUNT_WIDTH-1:0] danger_run_next,
    output logic [COUNT_WIDTH-1:0] glitch_count_next,
    output logic [COUNT_WIDTH-1:0] escalation_count_next,
    output sie_pkg::out_item_t  result
);

    // compare width covers both the counters and the 16-bit limits
    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] dr_inc;
    logic [COUNT_WIDTH-1:0] glitch_inc;
    logic [COUNT_WIDTH-1:0] esc_inc;
    logic [CMP_W-1:0]       thr_ext;
    logic [CMP_W-1:0]       t1_ext;
    logic [CMP_W-1:0]       t2_ext;
    logic [COUNT_WIDTH-1:0] glitch_report;
    logic                   triggered;
    logic                   dropped;
    logic                   entering;
    logic                   stopped;

    assign dr_inc     = (danger_run == '1) ? danger_run : danger_run + 1'b1;
    assign glitch_inc = (glitch_count == '1) ? glitch_count : glitch_count + 1'b1;
    assign esc_inc    = (escalation_count == '1) ? escalation_count
                                                 : escalation_count + 1'b1;
    assign thr_ext    = CMP_W'(cfg.glitch_limit);
    assign t1_ext     = CMP_W'(cfg.escalate_t1_ticks);
    assign t2_ext     = CMP_W'(cfg.escalate_t2_ticks);
    assign stopped    = !item.zero_speed_level;

    always_comb
    begin
        nxt                   = cur;
        danger_run_next       = danger_run;
        glitch_count_next     = glitch_count;
        escalation_count_next = escalation_count;
        glitch_report         = glitch_count;
        triggered             = 1'b0;
        dropped               = 1'b0;
        entering              = 1'b0;

        case (item.op)
            sie_pkg::OP_TICK:
            begin
                // e-stop filter
                if (item.estop_level == cfg.estop_danger_high)
                begin
                    danger_run_next = dr_inc;
                    if (CMP_W'(dr_inc) >= thr_ext)
                    begin
                        nxt.flags.estop = 1'b1;
                        triggered       = 1'b1;
                    end
                end
                else
                begin
                    if ((danger_run != '0) && (CMP_W'(danger_run) < thr_ext))
                    begin
                        glitch_count_next = glitch_inc;
                    end
                    nxt.flags.estop = 1'b0;
                    danger_run_next = '0;
                end

                dropped       = cur.prev_link && !item.link_connected;
                nxt.prev_link = item.link_connected;

                // safety sequence
                case (cur.mode)
                    sie_pkg::MODE_PANIC:
                    begin
                        if (item.link_connected && cur.link_fault_latch)
                        begin
                            nxt.link_fault_latch = 1'b0;
                            nxt.flags.link       = 1'b0;
                        end
                        // latch is released above whenever the link is present
                        if (!triggered && item.link_connected)
                        begin
                            nxt.flags.sw   = 1'b0;
                            nxt.mode       = sie_pkg::MODE_CLEAR;
                            nxt.calm_count = '0;
                        end
                    end
                    sie_pkg::MODE_CLEAR:
                    begin
                        if (cur.calm_count < cfg.calm_sweep_ticks)
                        begin
                            nxt.calm_count = cur.calm_count + 16'd1;
                        end
                        if (triggered)
                        begin
                            nxt.mode = sie_pkg::MODE_PANIC;
                        end
                        else if (dropped)
                        begin
                            nxt.link_fault_latch = 1'b1;
                            nxt.flags.link       = 1'b1;
                            nxt.mode             = sie_pkg::MODE_PANIC;
                        end
                        else if (!item.ack_level)
                        begin
                            nxt.mode         = sie_pkg::MODE_READY;
                            nxt.settle_count = '0;
                        end
                    end
                    sie_pkg::MODE_READY:
                    begin
                        if (triggered)
                        begin
                            nxt.mode         = sie_pkg::MODE_PANIC;
                            nxt.settle_count = '0;
                        end
                        else if (dropped)
                        begin
                            nxt.link_fault_latch = 1'b1;
                            nxt.flags.link       = 1'b1;
                            nxt.mode             = sie_pkg::MODE_PANIC;
                            nxt.settle_count     = '0;
                        end
                        else if (cur.settle_count >= cfg.settle_ticks)
                        begin
                            nxt.mode = sie_pkg::MODE_OK;
                        end
                        else
                        begin
                            nxt.settle_count = cur.settle_count + 16'd1;
                        end
                    end
                    default:
                    begin
                        if (triggered)
                        begin
                            nxt.mode = sie_pkg::MODE_PANIC;
                        end
                        else if (!item.link_connected)
                        begin
                            nxt.link_fault_latch = 1'b1;
                            nxt.flags.link       = 1'b1;
                            nxt.mode             = sie_pkg::MODE_PANIC;
                        end
                    end
                endcase

                // zero-speed watchdog
                entering = (nxt.mode == sie_pkg::MODE_PANIC)
                        && (cur.prev_mode != sie_pkg::MODE_PANIC);
                if (nxt.mode == sie_pkg::MODE_OK)
                begin
                    nxt.escalation        = sie_pkg::ESC_IDLE;
                    escalation_count_next = '0;
                end
                else if (entering && (cur.escalation == sie_pkg::ESC_IDLE))
                begin
                    nxt.escalation        = sie_pkg::ESC_MON;
                    escalation_count_next = '0;
                end
                else if ((nxt.mode == sie_pkg::MODE_PANIC)
                         && (cur.escalation == sie_pkg::ESC_MON))
                begin
                    if (stopped)
                    begin
                        nxt.escalation        = sie_pkg::ESC_IDLE;
                        escalation_count_next = '0;
                    end
                    else if (CMP_W'(esc_inc) >= t1_ext)
                    begin
                        nxt.escalation        = sie_pkg::ESC_HW;
                        escalation_count_next = '0;
                    end
                    else
                    begin
                        escalation_count_next = esc_inc;
                    end
                end
                else if ((nxt.mode == sie_pkg::MODE_PANIC)
                         && (cur.escalation == sie_pkg::ESC_HW))
                begin
                    if (!stopped)
                    begin
                        escalation_count_next = esc_inc;
                        if (CMP_W'(esc_inc) >= t2_ext)
                        begin
                            nxt.escalation = sie_pkg::ESC_CONT;
                        end
                    end
                end
                nxt.prev_mode = nxt.mode;
                glitch_report = glitch_count_next;
            end
            sie_pkg::OP_FORCE_ESTOP:
            begin
                nxt.mode         = sie_pkg::MODE_PANIC;
                nxt.flags.sw     = 1'b1;
                nxt.settle_count = '0;
                danger_run_next  = '0;
            end
            sie_pkg::OP_CLEAR_GLITCH:
            begin
                glitch_count_next = '0;
            end
            default:
            begin
                // unused op: report only
            end
        endcase
    end

    always_comb
    begin
        result.safety_mode          = nxt.mode;
        result.escalation_level     = nxt.escalation;
        result.contactor_relay_on   = (nxt.escalation != sie_pkg::ESC_CONT);
        result.hw_estop_relay_on    = (nxt.escalation == sie_pkg::ESC_IDLE)
                                   || (nxt.escalation == sie_pkg::ESC_MON);
        result.calm_progress        = nxt.calm_count;
        result.settle_progress      = nxt.settle_count;
        result.glitch_total         = 16'(glitch_report);
        result.panic_estop_input    = nxt.flags.estop;
        result.panic_software_estop = nxt.flags.sw;
        result.panic_link_lost      = nxt.flags.link;
    end

endmodule

[hdl/safety_interlock_escalation_fsm.sv]
`timescale 1ns / 1ps
// top level of the safety interlock and escalation sequencer
// depends on sie_pkg and sie_step
//
//  channel   handshake              payload      direction
//  in        in_valid / in_ready    in_item      item into the block
//  out       out_valid / out_ready  out_item     one result item per input item
//  cfg       cfg_write              cfg_index,   register write, no wait
//                                   cfg_data
//
// one item per clock sustained while out_ready stays high; an accepted item
// moves from the input register to the result register through the single
// pass of sie_step between them
// rst_n clears valids and sequencer state: mode panic, watchdog idle,
// counters zero, registers at their reset values
// a stalled result holds the result register and, one deep behind it, the
// input register; in_ready drops only when both are full and out_ready is low

module safety_interlock_escalation_fsm #(
    parameter int COUNT_WIDTH = sie_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  sie_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output sie_pkg::out_item_t                    out_item,
    input  logic                                  cfg_write,
    input  logic [sie_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [sie_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    // configuration registers
    sie_pkg::cfg_t cfg_reg;

    // pipeline registers
    logic               in_valid_reg;
    logic               in_valid_next;
    sie_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    sie_pkg::out_item_t out_item_reg;

    // sequencer state
    sie_pkg::seq_state_t    seq_reg;
    sie_pkg::seq_state_t    seq_next;
    logic [COUNT_WIDTH-1:0] danger_run_reg;
    logic [COUNT_WIDTH-1:0] danger_run_next;
    logic [COUNT_WIDTH-1:0] glitch_count_reg;
    logic [COUNT_WIDTH-1:0] glitch_count_next;
    logic [COUNT_WIDTH-1:0] escalation_count_reg;
    logic [COUNT_WIDTH-1:0] escalation_count_next;
    sie_pkg::out_item_t     result;

    logic advance;  // result register can take a new item
    logic process;  // the held input item is worked this cycle

    assign advance   = !out_valid_reg || out_ready;
    assign process   = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // config write port, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glitch_limit      <= 16'd5;
            cfg_reg.calm_sweep_ticks  <= 16'd100;
            cfg_reg.settle_ticks      <= 16'd50;
            cfg_reg.escalate_t1_ticks <= 16'd200;
            cfg_reg.escalate_t2_ticks <= 16'd400;
            cfg_reg.estop_danger_high <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sie_pkg::REG_GLITCH_LIMIT:      cfg_reg.glitch_limit      <= cfg_data;
                sie_pkg::REG_CALM_SWEEP_TICKS:  cfg_reg.calm_sweep_ticks  <= cfg_data;
                sie_pkg::REG_SETTLE_TICKS:      cfg_reg.settle_ticks      <= cfg_data;
                sie_pkg::REG_ESCALATE_T1_TICKS: cfg_reg.escalate_t1_ticks <= cfg_data;
                sie_pkg::REG_ESCALATE_T2_TICKS: cfg_reg.escalate_t2_ticks <= cfg_data;
                sie_pkg::REG_ESTOP_DANGER_HIGH: cfg_reg.estop_danger_high <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (process)
        begin
            out_item_reg <= result;
        end
    end

    // per-item logic
    sie_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item                  (in_item_reg),
        .cfg                   (cfg_reg),
        .cur                   (seq_reg),
        .danger_run            (danger_run_reg),
        .glitch_count          (glitch_count_reg),
        .escalation_count      (escalation_count_reg),
        .nxt                   (seq_next),
        .danger_run_next       (danger_run_next),
        .glitch_count_next     (glitch_count_next),
        .escalation_count_next (escalation_count_next),
        .result                (result)
    );

    // sequencer state advances once per worked item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.mode             <= sie_pkg::MODE_PANIC;
            seq_reg.prev_mode        <= sie_pkg::MODE_OK;
            seq_reg.escalation       <= sie_pkg::ESC_IDLE;
            seq_reg.calm_count       <= '0;
            seq_reg.settle_count     <= '0;
            seq_reg.prev_link        <= 1'b0;
            seq_reg.link_fault_latch <= 1'b0;
            seq_reg.flags            <= '0;
            danger_run_reg           <= '0;
            glitch_count_reg         <= '0;
            escalation_count_reg     <= '0;
        end
        else if (process)
        begin
            seq_reg              <= seq_next;
            danger_run_reg       <= danger_run_next;
            glitch_count_reg     <= glitch_count_next;
            escalation_count_reg <= escalation_count_next;
        end
    end

    // watchdog is always idle once the sequence reaches ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.mode == sie_pkg::MODE_OK) |-> (seq_reg.escalation == sie_pkg::ESC_IDLE))
        else $error("watchdog active in ok mode");

    // a latched link fault keeps the sequence in panic and its flag raised
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.link_fault_latch |->
            ((seq_reg.mode == sie_pkg::MODE_PANIC) && seq_reg.flags.link))
        else $error("link fault latch without panic or flag");

    // an item waiting in the input register is worked as soon as the output frees
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("worked item did not reach the result register");

    // a result held under stall does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_item_reg) && $stable(seq_reg))
        else $error("result or state moved during output stall");

endmodule

[dv/tb_safety_interlock_escalation_fsm.sv]
`timescale 1ns / 1ps
// self-checking testbench for the safety interlock and escalation sequencer
// depends on sie_pkg and safety_interlock_escalation_fsm, which also needs sie_step

module tb_safety_interlock_escalation_fsm;

    // op code 3 has no name in the package, the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // result register sits two stages behind the input, give it a margin
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_PERCENT = 23;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    sie_pkg::in_item_t   in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sie_pkg::out_item_t  out_item;
    logic                cfg_write = 1'b0;
    logic [sie_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [sie_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    // side-channel controls shared by the test tasks and the two drivers
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    int receiver_hold   = 0;
    int error_count     = 0;

    // results predicted for accepted items, oldest first
    sie_pkg::out_item_t expected_reports[$];

    // predictor copy of the block registers and sequencer state
    sie_pkg::cfg_t         cfg_shadow;
    logic [1:0]            mode_now;
    logic [1:0]            mode_last;
    logic [1:0]            esc_now;
    logic [15:0]           esc_count;
    logic [15:0]           danger_run;
    logic [15:0]           glitch_count;
    logic [15:0]           calm_count;
    logic [15:0]           settle_count;
    logic                  link_last;
    logic                  link_fault;
    sie_pkg::panic_flags_t flags;

    safety_interlock_escalation_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // interlock predictor
    // ------------------------------------------------------------------

    task automatic reset_interlock_model();
        cfg_shadow.glitch_limit      = 16'd5;
        cfg_shadow.calm_sweep_ticks  = 16'd100;
        cfg_shadow.settle_ticks      = 16'd50;
        cfg_shadow.escalate_t1_ticks = 16'd200;
        cfg_shadow.escalate_t2_ticks = 16'd400;
        cfg_shadow.estop_danger_high = 1'b1;
        mode_now     = sie_pkg::MODE_PANIC;
        mode_last    = sie_pkg::MODE_OK;
        esc_now      = sie_pkg::ESC_IDLE;
        esc_count    = '0;
        danger_run   = '0;
        glitch_count = '0;
        calm_count   = '0;
        settle_count = '0;
        link_last    = 1'b0;
        link_fault   = 1'b0;
        flags        = '0;
    endtask

    // counters stick at all ones
    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic drop_to_link_fault();
        link_fault = 1'b1;
        flags.link = 1'b1;
        mode_now   = sie_pkg::MODE_PANIC;
    endtask

    task automatic interlock_tick(input sie_pkg::in_item_t it);
        logic stopped;
        logic ack_down;
        logic triggered;
        logic dropped;
        logic entering;
        stopped   = ~it.zero_speed_level;
        ack_down  = ~it.ack_level;
        triggered = 1'b0;

        // e-stop filter: a long enough danger run triggers, a short one is a glitch
        if (it.estop_level == cfg_shadow.estop_danger_high)
        begin
            danger_run = bump16(danger_run);
            if (danger_run >= cfg_shadow.glitch_limit)
            begin
                flags.estop = 1'b1;
                triggered   = 1'b1;
            end
        end
        else
        begin
            if (danger_run != 16'd0 && danger_run < cfg_shadow.glitch_limit)
                glitch_count = bump16(glitch_count);
            flags.estop = 1'b0;
            danger_run  = '0;
        end

        dropped   = link_last & ~it.link_connected;
        link_last = it.link_connected;

        case (mode_now)
            sie_pkg::MODE_PANIC:
            begin
                // link back releases the latch, then leave panic if all calm
                if (it.link_connected && link_fault)
                begin
                    link_fault = 1'b0;
                    flags.link = 1'b0;
                end
                if (!triggered && !link_fault && it.link_connected)
                begin
                    flags.sw   = 1'b0;
                    mode_now   = sie_pkg::MODE_CLEAR;
                    calm_count = '0;
                end
            end
            sie_pkg::MODE_CLEAR:
            begin
                if (calm_count < cfg_shadow.calm_sweep_ticks)
                    calm_count = calm_count + 16'd1;
                if (triggered)
                    mode_now = sie_pkg::MODE_PANIC;
                else if (dropped)
                    drop_to_link_fault();
                else if (ack_down)
                begin
                    mode_now     = sie_pkg::MODE_READY;
                    settle_count = '0;
                end
            end
            sie_pkg::MODE_READY:
            begin
                if (triggered)
                begin
                    mode_now     = sie_pkg::MODE_PANIC;
                    settle_count = '0;
                end
                else if (dropped)
                begin
                    drop_to_link_fault();
                    settle_count = '0;
                end
                else if (settle_count >= cfg_shadow.settle_ticks)
                    mode_now = sie_pkg::MODE_OK;
                else
                    settle_count = settle_count + 16'd1;
            end
            default:
            begin
                // in ok a low link level is enough, no edge needed
                if (triggered)
                    mode_now = sie_pkg::MODE_PANIC;
                else if (!it.link_connected)
                    drop_to_link_fault();
            end
        endcase

        // zero-speed watchdog
        entering = (mode_now == sie_pkg::MODE_PANIC) && (mode_last != sie_pkg::MODE_PANIC);
        if (mode_now == sie_pkg::MODE_OK)
        begin
            esc_now   = sie_pkg::ESC_IDLE;
            esc_count = '0;
        end
        else if (entering && esc_now == sie_pkg::ESC_IDLE)
        begin
            esc_now   = sie_pkg::ESC_MON;
            esc_count = '0;
        end
        else if (mode_now == sie_pkg::MODE_PANIC && esc_now == sie_pkg::ESC_MON)
        begin
            if (stopped)
            begin
                esc_now   = sie_pkg::ESC_IDLE;
                esc_count = '0;
            end
            else
            begin
                esc_count = bump16(esc_count);
                if (esc_count >= cfg_shadow.escalate_t1_ticks)
                begin
                    esc_now   = sie_pkg::ESC_HW;
                    esc_count = '0;
                end
            end
        end
        else if (mode_now == sie_pkg::MODE_PANIC && esc_now == sie_pkg::ESC_HW)
        begin
            if (!stopped)
            begin
                esc_count = bump16(esc_count);
                if (esc_count >= cfg_shadow.escalate_t2_ticks)
                    esc_now = sie_pkg::ESC_CONT;
            end
        end
        mode_last = mode_now;
    endtask

    task automatic advance_interlock(input sie_pkg::in_item_t it,
                                     output sie_pkg::out_item_t rpt);
        logic [15:0] glitch_seen;
        case (it.op)
            sie_pkg::OP_TICK:
            begin
                interlock_tick(it);
                glitch_seen = glitch_count;
            end
            sie_pkg::OP_FORCE_ESTOP:
            begin
                // watchdog and previous mode untouched, next tick sees the entry
                mode_now     = sie_pkg::MODE_PANIC;
                flags.sw     = 1'b1;
                settle_count = '0;
                danger_run   = '0;
                glitch_seen  = glitch_count;
            end
            sie_pkg::OP_CLEAR_GLITCH:
            begin
                glitch_seen  = glitch_count;
                glitch_count = '0;
            end
            default:
                glitch_seen = glitch_count;
        endcase
        rpt.safety_mode          = mode_now;
        rpt.escalation_level     = esc_now;
        rpt.contactor_relay_on   = (esc_now != sie_pkg::ESC_CONT);
        rpt.hw_estop_relay_on    = (esc_now < sie_pkg::ESC_HW);
        rpt.calm_progress        = calm_count;
        rpt.settle_progress      = settle_count;
        rpt.glitch_total         = glitch_seen;
        rpt.panic_estop_input    = flags.estop;
        rpt.panic_software_estop = flags.sw;
        rpt.panic_link_lost      = flags.link;
    endtask

    // ------------------------------------------------------------------
    // result checker, samples at the rising edge
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        sie_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: result item with nothing expected, expected none actual %h",
                         $time, out_item);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("safety_mode", want.safety_mode, out_item.safety_mode);
                check_field("escalation_level", want.escalation_level,
                            out_item.escalation_level);
                check_field("contactor_relay_on", want.contactor_relay_on,
                            out_item.contactor_relay_on);
                check_field("hw_estop_relay_on", want.hw_estop_relay_on,
                            out_item.hw_estop_relay_on);
                check_field("calm_progress", want.calm_progress, out_item.calm_progress);
                check_field("settle_progress", want.settle_progress,
                            out_item.settle_progress);
                check_field("glitch_total", want.glitch_total, out_item.glitch_total);
                check_field("panic_estop_input", want.panic_estop_input,
                            out_item.panic_estop_input);
                check_field("panic_software_estop", want.panic_software_estop,
                            out_item.panic_software_estop);
                check_field("panic_link_lost", want.panic_link_lost,
                            out_item.panic_link_lost);
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls, steady mode, or a counted hold-off
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (receiver_hold > 0)
        begin
            out_ready = 1'b0;
            receiver_hold--;
        end
        else if (receiver_steady)
            out_ready = 1'b1;
        else
            out_ready = ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // input side and register access
    // ------------------------------------------------------------------

    // offer one item from a falling edge, predict it once accepted;
    // valid stays high between back-to-back items
    task automatic send_item(input sie_pkg::in_item_t it);
        sie_pkg::out_item_t rpt;
        @(negedge clk);
        while (!sender_steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        advance_interlock(it, rpt);
        expected_reports.push_back(rpt);
    endtask

    // stop offering and let every pending result come out
    task automatic wait_quiet();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sie_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [sie_pkg::CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            sie_pkg::REG_GLITCH_LIMIT:      cfg_shadow.glitch_limit      = data;
            sie_pkg::REG_CALM_SWEEP_TICKS:  cfg_shadow.calm_sweep_ticks  = data;
            sie_pkg::REG_SETTLE_TICKS:      cfg_shadow.settle_ticks      = data;
            sie_pkg::REG_ESCALATE_T1_TICKS: cfg_shadow.escalate_t1_ticks = data;
            sie_pkg::REG_ESCALATE_T2_TICKS: cfg_shadow.escalate_t2_ticks = data;
            sie_pkg::REG_ESTOP_DANGER_HIGH: cfg_shadow.estop_danger_high = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // registers change only with the block drained
    task automatic program_regs(input logic [15:0] threshold, input logic [15:0] calm,
                                input logic [15:0] settle, input logic [15:0] t1,
                                input logic [15:0] t2, input logic danger_high);
        wait_quiet();
        write_reg(sie_pkg::REG_GLITCH_LIMIT, threshold);
        write_reg(sie_pkg::REG_CALM_SWEEP_TICKS, calm);
        write_reg(sie_pkg::REG_SETTLE_TICKS, settle);
        write_reg(sie_pkg::REG_ESCALATE_T1_TICKS, t1);
        write_reg(sie_pkg::REG_ESCALATE_T2_TICKS, t2);
        write_reg(sie_pkg::REG_ESTOP_DANGER_HIGH, {15'd0, danger_high});
    endtask

    function automatic sie_pkg::in_item_t tick_item(input logic link, input logic estop,
                                                    input logic ack, input logic zs);
        sie_pkg::in_item_t it;
        it.op               = sie_pkg::OP_TICK;
        it.link_connected   = link;
        it.estop_level      = estop;
        it.ack_level        = ack;
        it.zero_speed_level = zs;
        return it;
    endfunction

    // non-tick ops carry random pin levels, the block must ignore them
    function automatic sie_pkg::in_item_t op_item(input logic [1:0] code);
        sie_pkg::in_item_t it;
        logic [3:0]        noise;
        noise = 4'($urandom_range(15));
        it.op = code;
        {it.link_connected, it.estop_level, it.ack_level, it.zero_speed_level} = noise;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // walk the sequence and the watchdog through every state once
    task automatic test_directed_walk();
        program_regs(16'd3, 16'd2, 16'd2, 16'd2, 16'd2, 1'b1);
        send_item(op_item(OP_UNUSED));              // reports reset state only
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1)); // entry into panic, monitoring
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1));
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1)); // hw estop
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1));
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1)); // contactor cut
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0)); // link up, go to clear
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b0)); // short danger pulse
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0)); // counted as glitch
        send_item(op_item(sie_pkg::OP_CLEAR_GLITCH));
        send_item(tick_item(1'b1, 1'b0, 1'b0, 1'b0)); // ack pressed, ready
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0)); // settled, ok
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1)); // link low in ok latches
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b0)); // zero speed drops watchdog
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0)); // latch released
        send_item(op_item(sie_pkg::OP_FORCE_ESTOP));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b1)); // triggered, panic
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b1));
    endtask

    // zero and all-ones register values, low-active e-stop polarity
    task automatic test_register_extremes();
        int i;
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_item(op_item(sie_pkg::OP_FORCE_ESTOP));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 1'b1)); // first counted tick escalates
        send_item(tick_item(1'b0, 1'b1, 1'b1, 1'b1));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b1)); // every danger tick triggers
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b1, 1'b0, 1'b1));
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b1));
        send_item(tick_item(1'b1, 1'b1, 1'b1, 1'b1));

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0));
        for (i = 0; i < 6; i++)
            send_item(tick_item(1'b1, 1'(i == 2), 1'(i != 3), 1'b0));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 1'b0));
        send_item(tick_item(1'b0, 1'b0, 1'b1, 1'b1)); // falling link edge in ready
        send_item(op_item(sie_pkg::OP_CLEAR_GLITCH));
    endtask

    // result side held off while items keep coming, input must stall
    task automatic test_output_backpressure();
        int i;
        program_regs(16'd2, 16'd4, 16'd3, 16'd5, 16'd4, 1'b1);
        sender_steady = 1'b1;
        receiver_hold = 60;
        for (i = 0; i < 20; i++)
            send_item(tick_item(1'b1, 1'(i % 7 == 3), 1'(i % 5 != 0), 1'(i[1])));
        sender_steady = 1'b0;
    endtask

    // mostly well-formed runs: mostly link up, danger bursts, zero speed that holds
    task automatic run_random_phase(input int count);
        int                i;
        int                danger_left;
        int                link_left;
        int                pick;
        logic              zs;
        logic              link;
        logic              estop;
        logic              ack;
        sie_pkg::in_item_t it;
        danger_left = 0;
        link_left   = 0;
        zs          = 1'b1;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                it = op_item(sie_pkg::OP_FORCE_ESTOP);
            else if (pick < 8)
                it = op_item(sie_pkg::OP_CLEAR_GLITCH);
            else if (pick < 10)
                it = op_item(OP_UNUSED);
            else if (pick < 16)
                it = 6'($urandom_range(63));    // noise
            else
            begin
                if (danger_left == 0 && $urandom_range(99) < 10)
                    danger_left = $urandom_range(1, 9);
                estop = (danger_left > 0) ? cfg_shadow.estop_danger_high
                                          : ~cfg_shadow.estop_danger_high;
                if (danger_left > 0)
                    danger_left--;
                if (link_left == 0 && $urandom_range(99) < 4)
                    link_left = $urandom_range(1, 3);
                link = (link_left == 0);
                if (link_left > 0)
                    link_left--;
                if ($urandom_range(99) < 10)
                    zs = ~zs;
                ack = ($urandom_range(99) >= 35);
                it = tick_item(link, estop, ack, zs);
            end
            send_item(it);
        end
    endtask

    task automatic test_random_regression();
        int phase;
        for (phase = 0; phase < 8; phase++)
        begin
            program_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                         16'($urandom_range(0, 8)), 16'($urandom_range(0, 12)),
                         16'($urandom_range(0, 12)), 1'($urandom_range(1)));
            // one phase runs with no idling on either side
            sender_steady   = (phase == 3);
            receiver_steady = (phase == 3);
            run_random_phase(124);
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------

    initial
    begin
        reset_interlock_model();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed_walk();
        test_register_extremes();
        test_output_backpressure();
        test_random_regression();
        wait_quiet();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
